// ===== hdl/ipaf_pkg.sv =====
// Package for the IPv4 port activity filter: frame summary type, verdict codes,
// header offsets and queue sizing. No dependencies.
`default_nettype none

package ipaf_pkg;

   localparam int PORT_SLOTS_DEFAULT = 7;
   localparam int MAX_FRAME_DEFAULT  = 1514;

   localparam int BYTE_IDX_W  = 11;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int PORT_W      = 16;
   localparam int ADDR_W      = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PORT_ENABLE = 3'd7;

   localparam logic [BYTE_IDX_W-1:0] OFF_TYPE_HI = 11'd12;
   localparam logic [BYTE_IDX_W-1:0] OFF_TYPE_LO = 11'd13;
   localparam logic [BYTE_IDX_W-1:0] OFF_IP_HDR  = 11'd14;
   localparam logic [BYTE_IDX_W-1:0] OFF_PROTO   = 11'd23;
   localparam logic [BYTE_IDX_W-1:0] OFF_PROTO_DONE = 11'd24;
   localparam logic [BYTE_IDX_W-1:0] OFF_SRC_IP0 = 11'd26;
   localparam logic [BYTE_IDX_W-1:0] OFF_SRC_IP1 = 11'd27;
   localparam logic [BYTE_IDX_W-1:0] OFF_SRC_IP2 = 11'd28;
   localparam logic [BYTE_IDX_W-1:0] OFF_SRC_IP3 = 11'd29;

   localparam logic [7:0] ETHERTYPE_HI = 8'h08;
   localparam logic [7:0] ETHERTYPE_LO = 8'h00;
   localparam logic [7:0] PROTO_TCP    = 8'h06;
   localparam logic [7:0] PROTO_UDP    = 8'h11;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      VERDICT_NOT_IPV4    = 3'd0,
      VERDICT_NOT_TCP_UDP = 3'd1,
      VERDICT_NO_MATCH    = 3'd2,
      VERDICT_IMPORTANT   = 3'd3,
      VERDICT_TRUNCATED   = 3'd4
   } verdict_type;

   typedef struct packed {
      verdict_type        verdict;
      logic [PORT_W-1:0]  src_port;
      logic [PORT_W-1:0]  dest_port;
      logic [ADDR_W-1:0]  src_addr;
   } frame_summary_type;

endpackage

`default_nettype wire

// ===== hdl/ipv4_port_activity_filter_core.sv =====
// Top level of the IPv4 TCP/UDP port activity filter: parser, summary queue
// and matcher. Depends on ipaf_pkg, ipaf_front, ipaf_queue, ipaf_back.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    frame_byte, last_byte
//   rsp      out        rsp_valid/stall    verdict, src_port, dest_port, src_addr
//   csr      in         csr_write          csr_index, csr_wdata
//
// One frame byte per cycle while req_stall is low; one result per frame, sent
// via the queue and the result register. The parser register set bounds the rate.
// Synchronous active-high reset clears frame state, port table and queue.
// req_stall rises only when the two-entry summary queue is full, i.e. when
// rsp_stall has held results back for several frames.
`default_nettype none

module ipv4_port_activity_filter_core #(
   parameter int PORT_SLOTS = ipaf_pkg::PORT_SLOTS_DEFAULT,
   parameter int MAX_FRAME  = ipaf_pkg::MAX_FRAME_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_frame_byte,
   input  wire logic                              req_last_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [2:0]                             rsp_verdict,
   output logic [ipaf_pkg::PORT_W-1:0]            rsp_src_port,
   output logic [ipaf_pkg::PORT_W-1:0]            rsp_dest_port,
   output logic [ipaf_pkg::ADDR_W-1:0]            rsp_src_addr,
   input  wire logic                              csr_write,
   input  wire logic [ipaf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ipaf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                        queue_full;
   logic                        queue_not_empty;
   logic                        push;
   logic                        pop;
   ipaf_pkg::frame_summary_type push_entry;
   ipaf_pkg::frame_summary_type head;

   ipaf_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_frame_byte (req_frame_byte),
      .req_last_byte  (req_last_byte),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   ipaf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   ipaf_back #(
      .PORT_SLOTS (PORT_SLOTS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .not_empty     (queue_not_empty),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_verdict   (rsp_verdict),
      .rsp_src_port  (rsp_src_port),
      .rsp_dest_port (rsp_dest_port),
      .rsp_src_addr  (rsp_src_addr)
   );

endmodule

`default_nettype wire

// ===== hdl/ipaf_front.sv =====
// Frame parser: walks the frame byte by byte and, on the last byte, pushes a
// frame summary into the queue. Depends on ipaf_pkg.
`default_nettype none

module ipaf_front #(
   parameter int MAX_FRAME = ipaf_pkg::MAX_FRAME_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_frame_byte,
   input  wire logic                      req_last_byte,
   input  wire logic                      queue_full,
   output logic                           push,
   output ipaf_pkg::frame_summary_type    push_entry
);

   localparam logic [ipaf_pkg::BYTE_IDX_W-1:0] MaxIdx = ipaf_pkg::BYTE_IDX_W'(MAX_FRAME);

   logic [ipaf_pkg::BYTE_IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [7:0]                      type_high_ff, type_high_in;
   logic                            is_ipv4_ff, is_ipv4_in;
   logic                            is_tcp_udp_ff, is_tcp_udp_in;
   logic [3:0]                      header_words_ff, header_words_in;
   logic [ipaf_pkg::ADDR_W-1:0]     src_addr_ff, src_addr_in;
   logic [ipaf_pkg::PORT_W-1:0]     src_port_ff, src_port_in;
   logic [ipaf_pkg::PORT_W-1:0]     dst_port_ff, dst_port_in;
   logic [2:0]                      ports_seen_ff, ports_seen_in;

   logic [ipaf_pkg::BYTE_IDX_W-1:0] base;
   logic [1:0]                      offset;
   logic                            accept;
   logic                            show;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && req_last_byte;

   always_comb begin
      byte_index_in   = byte_index_ff;
      type_high_in    = type_high_ff;
      is_ipv4_in      = is_ipv4_ff;
      is_tcp_udp_in   = is_tcp_udp_ff;
      header_words_in = header_words_ff;
      src_addr_in     = src_addr_ff;
      src_port_in     = src_port_ff;
      dst_port_in     = dst_port_ff;
      ports_seen_in   = ports_seen_ff;
      base            = '0;
      offset          = '0;

      if (byte_index_ff < MaxIdx) begin
         if (byte_index_ff == ipaf_pkg::OFF_TYPE_HI) begin
            type_high_in = req_frame_byte;
         end
         if (byte_index_ff == ipaf_pkg::OFF_TYPE_LO) begin
            is_ipv4_in = (type_high_ff == ipaf_pkg::ETHERTYPE_HI) &&
                         (req_frame_byte == ipaf_pkg::ETHERTYPE_LO);
         end
         if (byte_index_ff == ipaf_pkg::OFF_IP_HDR) begin
            header_words_in = req_frame_byte[3:0];
         end
         if (byte_index_ff == ipaf_pkg::OFF_PROTO) begin
            is_tcp_udp_in = (req_frame_byte == ipaf_pkg::PROTO_TCP) ||
                            (req_frame_byte == ipaf_pkg::PROTO_UDP);
         end
         if (byte_index_ff == ipaf_pkg::OFF_SRC_IP0) src_addr_in[31:24] = req_frame_byte;
         if (byte_index_ff == ipaf_pkg::OFF_SRC_IP1) src_addr_in[23:16] = req_frame_byte;
         if (byte_index_ff == ipaf_pkg::OFF_SRC_IP2) src_addr_in[15:8]  = req_frame_byte;
         if (byte_index_ff == ipaf_pkg::OFF_SRC_IP3) src_addr_in[7:0]   = req_frame_byte;

         // transport ports sit 4 * IHL bytes past the IP header start
         base   = ipaf_pkg::OFF_IP_HDR + {5'b0, header_words_in, 2'b00};
         offset = byte_index_ff[1:0] - base[1:0];
         if ((byte_index_ff >= base) && (byte_index_ff < base + 11'd4)) begin
            unique case (offset)
               2'd0: src_port_in[15:8] = req_frame_byte;
               2'd1: src_port_in[7:0]  = req_frame_byte;
               2'd2: dst_port_in[15:8] = req_frame_byte;
               default: dst_port_in[7:0] = req_frame_byte;
            endcase
            ports_seen_in = ports_seen_ff + 3'd1;
         end
         byte_index_in = byte_index_ff + 11'd1;
      end
   end

   always_comb begin
      show = 1'b1;
      priority if (byte_index_in < ipaf_pkg::OFF_IP_HDR) begin
         push_entry.verdict = ipaf_pkg::VERDICT_TRUNCATED;
      end else if (!is_ipv4_in) begin
         push_entry.verdict = ipaf_pkg::VERDICT_NOT_IPV4;
         show = 1'b0;
      end else if (byte_index_in < ipaf_pkg::OFF_PROTO_DONE) begin
         push_entry.verdict = ipaf_pkg::VERDICT_TRUNCATED;
      end else if (!is_tcp_udp_in) begin
         push_entry.verdict = ipaf_pkg::VERDICT_NOT_TCP_UDP;
         show = 1'b0;
      end else if (ports_seen_in < 3'd4) begin
         push_entry.verdict = ipaf_pkg::VERDICT_TRUNCATED;
      end else begin
         // resolved against the port table in the back end
         push_entry.verdict = ipaf_pkg::VERDICT_NO_MATCH;
      end
      push_entry.src_port  = show ? src_port_in : '0;
      push_entry.dest_port = show ? dst_port_in : '0;
      push_entry.src_addr  = show ? src_addr_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         byte_index_ff   <= '0;
         type_high_ff    <= '0;
         is_ipv4_ff      <= 1'b0;
         is_tcp_udp_ff   <= 1'b0;
         header_words_ff <= '0;
         src_addr_ff     <= '0;
         src_port_ff     <= '0;
         dst_port_ff     <= '0;
         ports_seen_ff   <= '0;
      end else if (accept) begin
         byte_index_ff   <= byte_index_in;
         type_high_ff    <= type_high_in;
         is_ipv4_ff      <= is_ipv4_in;
         is_tcp_udp_ff   <= is_tcp_udp_in;
         header_words_ff <= header_words_in;
         src_addr_ff     <= src_addr_in;
         src_port_ff     <= src_port_in;
         dst_port_ff     <= dst_port_in;
         ports_seen_ff   <= ports_seen_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ipaf_queue.sv =====
// Short queue of frame summaries between parser and matcher.
// Depends on ipaf_pkg.
`default_nettype none

module ipaf_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire ipaf_pkg::frame_summary_type push_entry,
   input  wire logic                      pop,
   output logic                           full,
   output logic                           not_empty,
   output ipaf_pkg::frame_summary_type    head
);

   localparam int Depth = ipaf_pkg::QUEUE_DEPTH;
   localparam int PtrW  = ipaf_pkg::QUEUE_PTR_W;
   localparam int CntW  = ipaf_pkg::QUEUE_CNT_W;

   ipaf_pkg::frame_summary_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign full      = (count_ff == CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ipaf_back.sv =====
// Matcher: holds the port table, resolves the verdict of each queued summary
// and drives the registered result channel. Depends on ipaf_pkg.
`default_nettype none

module ipaf_back #(
   parameter int PORT_SLOTS = ipaf_pkg::PORT_SLOTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [ipaf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ipaf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                not_empty,
   input  wire ipaf_pkg::frame_summary_type         head,
   output logic                                     pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [2:0]                               rsp_verdict,
   output logic [ipaf_pkg::PORT_W-1:0]              rsp_src_port,
   output logic [ipaf_pkg::PORT_W-1:0]              rsp_dest_port,
   output logic [ipaf_pkg::ADDR_W-1:0]              rsp_src_addr
);

   logic [ipaf_pkg::PORT_W-1:0] port_ff [PORT_SLOTS];
   logic [PORT_SLOTS-1:0]       enable_ff;
   logic [PORT_SLOTS-1:0]       slot_hit;
   logic                        rsp_valid_ff;
   ipaf_pkg::frame_summary_type rsp_ff, rsp_in;

   genvar g;
   generate
      for (g = 0; g < PORT_SLOTS; g++) begin : g_slot
         always_ff @(posedge clock) begin
            if (reset) begin
               port_ff[g] <= '0;
            end else if (csr_write && (csr_index == ipaf_pkg::CSR_INDEX_W'(g))) begin
               port_ff[g] <= csr_wdata;
            end
         end
         assign slot_hit[g] = enable_ff[g] &&
                              ((port_ff[g] == head.src_port) ||
                               (port_ff[g] == head.dest_port));
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
      end else if (csr_write && (csr_index == ipaf_pkg::CSR_PORT_ENABLE)) begin
         enable_ff <= csr_wdata[PORT_SLOTS-1:0];
      end
   end

   assign pop = not_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_in = head;
      if ((head.verdict == ipaf_pkg::VERDICT_NO_MATCH) && (|slot_hit)) begin
         rsp_in.verdict = ipaf_pkg::VERDICT_IMPORTANT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_verdict   = rsp_ff.verdict;
   assign rsp_src_port  = rsp_ff.src_port;
   assign rsp_dest_port = rsp_ff.dest_port;
   assign rsp_src_addr  = rsp_ff.src_addr;

endmodule

`default_nettype wire

// ===== test/ipv4_port_activity_filter_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ipv4_port_activity_filter_core: byte-stream driver,
// result monitor and a frame-level predictor of the port filter verdicts.
// Depends on ipaf_pkg and the core RTL only.

module ipv4_port_activity_filter_core_test;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SLOTS          = ipaf_pkg::PORT_SLOTS_DEFAULT;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   logic                             clock           = 1'b0;
   logic                             reset           = 1'b1;
   logic                             req_valid       = 1'b0;
   logic                             req_stall;
   logic [7:0]                       req_frame_byte  = 8'h00;
   logic                             req_last_byte   = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall       = 1'b0;
   logic [2:0]                       rsp_verdict;
   logic [ipaf_pkg::PORT_W-1:0]      rsp_src_port;
   logic [ipaf_pkg::PORT_W-1:0]      rsp_dest_port;
   logic [ipaf_pkg::ADDR_W-1:0]      rsp_src_addr;
   logic                             csr_write       = 1'b0;
   logic [ipaf_pkg::CSR_INDEX_W-1:0] csr_index       = '0;
   logic [ipaf_pkg::CSR_DATA_W-1:0]  csr_wdata       = '0;

   frame_byte_type              pending_bytes[$];
   ipaf_pkg::frame_summary_type expected_summaries[$];
   logic [7:0]                  frame_buf [0:2047];

   // predictor copy of the port table and of the per-frame parse state
   logic [15:0] watch_port [SLOTS];
   logic [6:0]  watch_enable;
   logic [15:0] next_port [SLOTS];
   int          frame_pos;
   logic [7:0]  type_hi;
   bit          ipv4_seen;
   bit          l4_seen;
   int          hdr_words;
   logic [31:0] src_ip_acc;
   logic [15:0] sport_acc;
   logic [15:0] dport_acc;
   int          port_bytes;

   int bytes_queued  = 0;
   int bytes_taken   = 0;
   int frames_done   = 0;
   int settings_done = 0;
   int error_count   = 0;
   int verdict_tally [5];
   int burst_left    = 0;
   int gap_left      = 0;
   int stall_mode    = 0;
   int stall_timer   = 0;
   int tick          = 0;
   int idle_cycles   = 0;

   ipv4_port_activity_filter_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_frame_byte (req_frame_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_verdict    (rsp_verdict),
      .rsp_src_port   (rsp_src_port),
      .rsp_dest_port  (rsp_dest_port),
      .rsp_src_addr   (rsp_src_addr),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   task clear_parse;
      frame_pos  = 0;
      type_hi    = '0;
      ipv4_seen  = 0;
      l4_seen    = 0;
      hdr_words  = 0;
      src_ip_acc = '0;
      sport_acc  = '0;
      dport_acc  = '0;
      port_bytes = 0;
   endtask

   // Advance the parse by one byte; on the last byte, queue the expected summary.
   task absorb_byte(input logic [7:0] b, input logic last);
      int                          base;
      int                          rel;
      bit                          hit;
      bit                          show;
      ipaf_pkg::frame_summary_type s;
      hit  = 0;
      show = 1;
      if (frame_pos < ipaf_pkg::MAX_FRAME_DEFAULT) begin
         if (frame_pos == ipaf_pkg::OFF_TYPE_HI) type_hi = b;
         if (frame_pos == ipaf_pkg::OFF_TYPE_LO)
            ipv4_seen = (type_hi == ipaf_pkg::ETHERTYPE_HI) && (b == ipaf_pkg::ETHERTYPE_LO);
         if (frame_pos == ipaf_pkg::OFF_IP_HDR) hdr_words = b[3:0];
         if (frame_pos == ipaf_pkg::OFF_PROTO)
            l4_seen = (b == ipaf_pkg::PROTO_TCP) || (b == ipaf_pkg::PROTO_UDP);
         if (frame_pos >= ipaf_pkg::OFF_SRC_IP0 && frame_pos <= ipaf_pkg::OFF_SRC_IP3)
            src_ip_acc[8 * (int'(ipaf_pkg::OFF_SRC_IP3) - frame_pos) +: 8] = b;
         base = int'(ipaf_pkg::OFF_IP_HDR) + 4 * hdr_words;
         if (frame_pos >= base && frame_pos < base + 4) begin
            rel = frame_pos - base;
            case (rel)
               0: sport_acc[15:8] = b;
               1: sport_acc[7:0]  = b;
               2: dport_acc[15:8] = b;
               default: dport_acc[7:0] = b;
            endcase
            port_bytes++;
         end
         frame_pos++;
      end
      if (last) begin
         if (frame_pos < ipaf_pkg::OFF_IP_HDR) begin
            s.verdict = ipaf_pkg::VERDICT_TRUNCATED;
         end else if (!ipv4_seen) begin
            s.verdict = ipaf_pkg::VERDICT_NOT_IPV4;
            show = 0;
         end else if (frame_pos < ipaf_pkg::OFF_PROTO_DONE) begin
            s.verdict = ipaf_pkg::VERDICT_TRUNCATED;
         end else if (!l4_seen) begin
            s.verdict = ipaf_pkg::VERDICT_NOT_TCP_UDP;
            show = 0;
         end else if (port_bytes < 4) begin
            s.verdict = ipaf_pkg::VERDICT_TRUNCATED;
         end else begin
            for (int i = 0; i < SLOTS; i++)
               if (watch_enable[i] &&
                   (watch_port[i] == sport_acc || watch_port[i] == dport_acc))
                  hit = 1;
            s.verdict = hit ? ipaf_pkg::VERDICT_IMPORTANT : ipaf_pkg::VERDICT_NO_MATCH;
         end
         s.src_port  = show ? sport_acc : '0;
         s.dest_port = show ? dport_acc : '0;
         s.src_addr  = show ? src_ip_acc : '0;
         expected_summaries.insert(expected_summaries.size(), s);
         clear_parse();
      end
   endtask

   function automatic logic [15:0] pick_port();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5) return watch_port[$urandom_range(0, SLOTS - 1)];
      if (r == 5) return 16'h0000;
      if (r == 6) return 16'hffff;
      return 16'($urandom);
   endfunction

   // Build a frame in frame_buf and queue its bytes; raw leaves the bytes random.
   task queue_frame(input int ihl, input logic [7:0] proto, input logic [15:0] src_port,
                    input logic [15:0] dst_port, input logic [15:0] ethertype,
                    input int len, input bit raw);
      int             base;
      frame_byte_type item;
      base = 14 + 4 * ihl;
      for (int i = 0; i < len; i++) frame_buf[i] = 8'($urandom);
      if (!raw) begin
         frame_buf[ipaf_pkg::OFF_TYPE_HI] = ethertype[15:8];
         frame_buf[ipaf_pkg::OFF_TYPE_LO] = ethertype[7:0];
         frame_buf[ipaf_pkg::OFF_IP_HDR]  = {4'h4, 4'(ihl)};
         frame_buf[ipaf_pkg::OFF_PROTO]   = proto;
         frame_buf[base]                  = src_port[15:8];
         frame_buf[base + 1]              = src_port[7:0];
         frame_buf[base + 2]              = dst_port[15:8];
         frame_buf[base + 3]              = dst_port[7:0];
      end
      for (int i = 0; i < len; i++) begin
         item.data = frame_buf[i];
         item.last = (i == len - 1);
         pending_bytes.insert(pending_bytes.size(), item);
         bytes_queued++;
      end
   endtask

   task queue_random_frame;
      int unsigned kind;
      int          ihl;
      int          need;
      int          len;
      logic [15:0] ethertype;
      logic [7:0]  proto;
      bit          raw;
      kind      = $urandom_range(0, 99);
      ihl       = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
      need      = (18 + 4 * ihl > 30) ? 18 + 4 * ihl : 30;
      len       = need + $urandom_range(0, 24);
      ethertype = {ipaf_pkg::ETHERTYPE_HI, ipaf_pkg::ETHERTYPE_LO};
      proto     = $urandom_range(0, 1) ? ipaf_pkg::PROTO_TCP : ipaf_pkg::PROTO_UDP;
      raw       = 0;
      if (kind < 12) begin
         len = $urandom_range(1, need - 1);
      end else if (kind < 20) begin
         ethertype = ethertype ^ (16'h0001 << $urandom_range(0, 15));
      end else if (kind < 27) begin
         proto = 8'($urandom);
      end else if (kind < 32) begin
         raw = 1;
         len = $urandom_range(1, 60);
      end
      queue_frame(ihl, proto, pick_port(), pick_port(), ethertype, len, raw);
   endtask

   // Hold until every queued byte is taken and every summary has come back.
   task wait_drained;
      while (bytes_taken != bytes_queued || expected_summaries.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task program_table(input logic [ipaf_pkg::CSR_DATA_W-1:0] enable_word);
      for (int i = 0; i < SLOTS; i++) begin
         @(posedge clock);
         csr_write     <= 1'b1;
         csr_index     <= ipaf_pkg::CSR_INDEX_W'(i);
         csr_wdata     <= next_port[i];
         watch_port[i]  = next_port[i];
      end
      @(posedge clock);
      csr_write    <= 1'b1;
      csr_index    <= ipaf_pkg::CSR_PORT_ENABLE;
      csr_wdata    <= enable_word;
      watch_enable  = enable_word[6:0];
      @(posedge clock);
      csr_write <= 1'b0;
      settings_done++;
   endtask

   task report_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin : driver
      frame_byte_type item;
      bit             took;
      if (reset) begin
         req_valid      <= 1'b0;
         req_frame_byte <= 8'h00;
         req_last_byte  <= 1'b0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            absorb_byte(req_frame_byte, req_last_byte);
            bytes_taken++;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                      : $urandom_range(0, 4);
         end
         if (!req_valid || took) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               item = pending_bytes.pop_front();
               req_valid      <= 1'b1;
               req_frame_byte <= item.data;
               req_last_byte  <= item.last;
               if (burst_left == 0)
                  burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 30);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern switches between modes every so often.
   always @(posedge clock) begin : monitor
      ipaf_pkg::frame_summary_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_summaries.size() == 0) begin
               $error("unexpected transaction: verdict %0d, src_port %0h, dest_port %0h",
                      rsp_verdict, rsp_src_port, rsp_dest_port);
               error_count++;
            end else begin
               want = expected_summaries.pop_front();
               report_field("verdict", 32'(want.verdict), 32'(rsp_verdict));
               report_field("src_port", 32'(want.src_port), 32'(rsp_src_port));
               report_field("dest_port", 32'(want.dest_port), 32'(rsp_dest_port));
               report_field("src_addr", want.src_addr, rsp_src_addr);
               if (want.verdict <= ipaf_pkg::VERDICT_TRUNCATED)
                  verdict_tally[want.verdict]++;
               frames_done++;
            end
         end
         tick++;
         if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(20, 200);
         end else begin
            stall_timer--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= (tick % 4 == 0);
            default: rsp_stall <= (tick % 16 < 11);
         endcase
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", idle_cycles);
         $display("ipv4_port_activity_filter_core_test: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int          phase_start;
      logic [15:0] enable_word;
      logic [15:0] eth_ipv4;
      clear_parse();
      for (int i = 0; i < SLOTS; i++) watch_port[i] = '0;
      watch_enable = '0;
      for (int i = 0; i < 5; i++) verdict_tally[i] = 0;
      eth_ipv4 = {ipaf_pkg::ETHERTYPE_HI, ipaf_pkg::ETHERTYPE_LO};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset port table: everything disabled
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'h0000, 16'h0000, eth_ipv4, 38, 0);
      queue_frame(0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1, 1);
      wait_drained();

      next_port = '{16'h0000, 16'd80, 16'd443, 16'd22, 16'd8080, 16'd53, 16'hffff};
      program_table(16'hff5f);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'd80, 16'd4321, eth_ipv4, 54, 0);
      queue_frame(5, ipaf_pkg::PROTO_UDP, 16'd5000, 16'hffff, eth_ipv4, 42, 0);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'd53, 16'd1234, eth_ipv4, 60, 0);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'h0000, 16'h0000, eth_ipv4, 38, 0);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'd80, 16'd80, 16'h86dd, 60, 0);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'd80, 16'd80, 16'h0801, 40, 0);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'd80, 16'd80, 16'h1800, 40, 0);
      queue_frame(5, 8'h01, 16'd80, 16'd80, eth_ipv4, 40, 0);
      queue_frame(0, ipaf_pkg::PROTO_TCP, 16'h0016, 16'd999, eth_ipv4, 30, 0);
      queue_frame(15, ipaf_pkg::PROTO_UDP, 16'd1, 16'd443, eth_ipv4, 78, 0);
      // header length 2: port bytes sit over the protocol byte
      queue_frame(2, ipaf_pkg::PROTO_TCP, 16'h4006, 16'd8080, eth_ipv4, 40, 0);
      // header length 3: port bytes sit over the source address
      queue_frame(3, ipaf_pkg::PROTO_UDP, 16'd22, 16'd2, eth_ipv4, 34, 0);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'd80, 16'd80, eth_ipv4, 5, 1);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'd80, 16'd80, eth_ipv4, 13, 0);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'd80, 16'd80, eth_ipv4, 14, 0);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'd80, 16'd80, eth_ipv4, 23, 0);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'd80, 16'd80, eth_ipv4, 24, 0);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'd80, 16'd80, eth_ipv4, 36, 0);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'd80, 16'd80, eth_ipv4, 37, 0);
      queue_frame(5, ipaf_pkg::PROTO_TCP, 16'd80, 16'd80, 16'h9100, 20, 0);
      wait_drained();

      for (int phase = 0; phase < 5; phase++) begin
         for (int i = 0; i < SLOTS; i++)
            case ($urandom_range(0, 5))
               0: next_port[i] = 16'h0000;
               1: next_port[i] = 16'hffff;
               default: next_port[i] = 16'($urandom);
            endcase
         enable_word = 16'($urandom);
         if (phase == 0) enable_word[6:0] = 7'h00;
         if (phase == 1) enable_word[6:0] = 7'h7f;
         program_table(enable_word);
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < 100) queue_random_frame();
         wait_drained();
      end

      $display("%0d frame bytes in %0d frames over %0d port table settings", bytes_taken,
               frames_done, settings_done);
      $display("verdicts: not ipv4 %0d, not tcp/udp %0d, no match %0d, important %0d,",
               verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3]);
      $display("          truncated %0d", verdict_tally[4]);
      if (error_count == 0)
         $display("ipv4_port_activity_filter_core_test: done, clean");
      else
         $display("ipv4_port_activity_filter_core_test: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/ipaf_pkg.sv
hdl/ipaf_front.sv
hdl/ipaf_queue.sv
hdl/ipaf_back.sv
hdl/ipv4_port_activity_filter_core.sv
test/ipv4_port_activity_filter_core_test.sv
